### src/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms used by the cache RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Condition must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

### src/lru_kv_pkg.sv
// ============================================================================
// LRU key-value cache package
// Widths, codes and the structs passed between the top level and the cells.
// ============================================================================
package lru_kv_pkg;

   localparam int DATA_W          = 32;
   localparam int CAP_W           = 5;
   localparam int DEF_MAX_ENTRIES = 16;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_SET = 1'b1;

   // Lookup word walking down the row of cells.
   typedef struct packed {
      logic              act;   // word present at this hop
      logic              done;  // search already ended upstream
      logic              hit;   // search ended on a matching entry
      logic [DATA_W-1:0] val;   // value of the matching entry
   } pkt_type;

   // Commit command broadcast to every cell at the end of a walk.
   typedef struct packed {
      logic commit;     // walk finished: clear marks
      logic shift;      // marked cells take their upstream neighbor's entry
      logic drop_last;  // marked empty cell stays empty (eviction)
   } upd_type;

endpackage

### src/lru_key_value_cache.sv
// ============================================================================
// LRU key-value cache
// Fully associative key-value store with least-recently-used replacement,
// built as a row of cells kept in recency order.
// ============================================================================
//
//   Channel   Ports                                        Direction  Flow
//   request   start, busy, req_opcode, req_key, req_value  in         start & !busy
//   response  rsp_strobe, rsp_hit, rsp_read_value,         out        one-cycle strobe
//             rsp_evicted
//   control   csr_valid, csr_ready, csr_data               in         valid & ready
//
// Each request word is served by one walk: the lookup word walks the row of
// cells one cell per cycle; when it leaves the last cell the shift is
// committed, and busy drops at the edge that raises the response strobe.
// The response appears for one cycle on rsp_strobe, in the cycle when busy
// is low again; it cannot be stalled, and a new word may be started then.
// Synchronous reset empties every cell, sets capacity to 16 and returns to
// idle at once; no clearing pass is needed. The capacity register is taken
// while the cache is idle.
//
module lru_key_value_cache #(
   parameter int MAX_ENTRIES = lru_kv_pkg::DEF_MAX_ENTRIES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_opcode,
   input  logic signed [lru_kv_pkg::DATA_W-1:0] req_key,
   input  logic signed [lru_kv_pkg::DATA_W-1:0] req_value,
   // response channel
   output logic                                 rsp_strobe,
   output logic                                 rsp_hit,
   output logic signed [lru_kv_pkg::DATA_W-1:0] rsp_read_value,
   output logic                                 rsp_evicted,
   // capacity register
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lru_kv_pkg::CAP_W-1:0]         csr_data
);
   import lru_kv_pkg::*;

   `include "assert_macros.svh"

   // Fill counter must hold MAX_ENTRIES itself; capacity compares use the
   // wider of the two widths.
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   // Control state.
   logic             state_ff,  state_in;
   logic             inject_ff, inject_in;
   logic [CNT_W-1:0] fill_ff,   fill_in;
   logic [CAP_W-1:0] cap_ff,    cap_in;

   // Request word held for the length of the walk.
   logic              op_ff,  op_in;
   logic [DATA_W-1:0] key_ff, key_in;
   logic [DATA_W-1:0] val_ff, val_in;

   // Response registers.
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic              rsp_hit_ff,    rsp_hit_in;
   logic [DATA_W-1:0] rsp_rd_ff,     rsp_rd_in;
   logic              rsp_evicted_ff, rsp_evicted_in;

   // Row of cells.
   pkt_type           pkt_q   [MAX_ENTRIES];
   logic              ent_vld [MAX_ENTRIES];
   logic [DATA_W-1:0] ent_key [MAX_ENTRIES];
   logic [DATA_W-1:0] ent_val [MAX_ENTRIES];
   pkt_type           head_pkt;
   pkt_type           tail_pkt;
   upd_type           upd;
   logic [DATA_W-1:0] head_val;

   logic             accept;
   logic             walk_end;
   logic             is_set;
   logic             full;
   logic             evict_now;
   logic [CMP_W-1:0] cap_ext;
   logic [CMP_W-1:0] max_ext;
   logic [CMP_W-1:0] eff_cap;
   logic [CMP_W-1:0] fill_ext;

   assign busy      = (state_ff == ST_WALK);
   assign csr_ready = (state_ff == ST_IDLE);
   assign accept    = start && !busy;

   // The search word enters cell 0 in the first cycle after acceptance and
   // is registered in each cell in turn before it leaves the last cell.
   assign head_pkt = '{act: inject_ff, done: 1'b0, hit: 1'b0, val: '0};
   assign tail_pkt = pkt_q[MAX_ENTRIES-1];
   assign walk_end = tail_pkt.act;
   assign is_set   = (op_ff == OP_SET);

   // Capacity zero behaves as one, and anything above the row length
   // saturates to the row length.
   assign cap_ext  = CMP_W'(cap_ff);
   assign max_ext  = CMP_W'(MAX_ENTRIES);
   assign fill_ext = CMP_W'(fill_ff);
   assign eff_cap  = (cap_ff == '0)       ? CMP_W'(1) :
                     (cap_ext > max_ext)  ? max_ext   : cap_ext;
   assign full     = (fill_ext >= eff_cap);

   // A new key on a full cache drops the least recent entry. Since the row
   // is kept in recency order, that is the last valid cell: the shift moves
   // it into the first empty cell, which is then told to stay empty. When
   // every cell is valid the entry simply falls off the end of the row.
   assign evict_now = walk_end && is_set && !tail_pkt.hit && full;

   // Cells in front of the matching entry (or, for an insert, in front of
   // the first empty cell) all move back by one; cell 0 takes the written
   // or looked-up entry. A get miss changes nothing.
   assign upd.commit    = walk_end;
   assign upd.shift     = walk_end && (tail_pkt.hit || is_set);
   assign upd.drop_last = evict_now;

   assign head_val = is_set ? val_ff : tail_pkt.val;

   genvar gi;
   generate
      for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
         if (gi == 0) begin : g_head
            lru_kv_cell u_cell (
               .clock    (clock),
               .reset    (reset),
               .req_key  (key_ff),
               .upd      (upd),
               .pkt_in   (head_pkt),
               .pkt_out  (pkt_q[gi]),
               .prev_vld (1'b1),
               .prev_key (key_ff),
               .prev_val (head_val),
               .ent_vld  (ent_vld[gi]),
               .ent_key  (ent_key[gi]),
               .ent_val  (ent_val[gi])
            );
         end else begin : g_body
            lru_kv_cell u_cell (
               .clock    (clock),
               .reset    (reset),
               .req_key  (key_ff),
               .upd      (upd),
               .pkt_in   (pkt_q[gi-1]),
               .pkt_out  (pkt_q[gi]),
               .prev_vld (ent_vld[gi-1]),
               .prev_key (ent_key[gi-1]),
               .prev_val (ent_val[gi-1]),
               .ent_vld  (ent_vld[gi]),
               .ent_key  (ent_key[gi]),
               .ent_val  (ent_val[gi])
            );
         end
      end
   endgenerate

   always_comb begin
      state_in  = state_ff;
      inject_in = 1'b0;
      fill_in   = fill_ff;
      cap_in    = cap_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      val_in    = val_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in  = ST_WALK;
               inject_in = 1'b1;
               op_in     = req_opcode;
               key_in    = req_key;
               val_in    = req_value;
            end
         end
         ST_WALK: begin
            if (walk_end) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // An insert without eviction grows the fill by one; everything else
      // leaves it alone.
      if (walk_end && is_set && !tail_pkt.hit && !full) begin
         fill_in = fill_ff + CNT_W'(1);
      end

      if (csr_valid && csr_ready) begin
         cap_in = csr_data;
      end

      rsp_strobe_in  = walk_end;
      rsp_hit_in     = tail_pkt.hit;
      rsp_rd_in      = (!is_set && tail_pkt.hit) ? tail_pkt.val : '0;
      rsp_evicted_in = evict_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         inject_ff     <= 1'b0;
         fill_ff       <= '0;
         cap_ff        <= CAP_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         inject_ff     <= inject_in;
         fill_ff       <= fill_in;
         cap_ff        <= cap_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      val_ff         <= val_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_rd_ff      <= rsp_rd_in;
      rsp_evicted_ff <= rsp_evicted_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_rd_ff;
   assign rsp_evicted    = rsp_evicted_ff;

   // A response word follows exactly one completed walk.
   `ASSERT_CLK(a_rsp_after_walk, clock, reset, rsp_strobe_ff |-> $past(walk_end), "response without a completed walk")

   // The search word only travels while the cache reports busy.
   `ASSERT_NEVER(a_idle_no_walk, clock, reset, (state_ff == ST_IDLE) && walk_end, "search word seen while idle")

   // The fill never exceeds the row length.
   `ASSERT_NEVER(a_fill_range, clock, reset, fill_ff > CNT_W'(MAX_ENTRIES), "fill count above row length")

   // An eviction replaces one entry, so the fill stays where it was.
   `ASSERT_CLK(a_evict_keeps_fill, clock, reset, (rsp_strobe_ff && rsp_evicted_ff) |-> (fill_ff == $past(fill_ff)), "fill changed on eviction")

endmodule

### src/lru_kv_cell.sv
// ============================================================================
// LRU key-value cache cell
// Holds one entry of the recency-ordered row, compares it with the lookup
// word as it passes, and shifts in its upstream neighbor's entry on commit.
// ============================================================================
`include "assert_macros.svh"

module lru_kv_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [lru_kv_pkg::DATA_W-1:0] req_key,
   input  lru_kv_pkg::upd_type           upd,
   input  lru_kv_pkg::pkt_type           pkt_in,
   output lru_kv_pkg::pkt_type           pkt_out,
   input  logic                          prev_vld,
   input  logic [lru_kv_pkg::DATA_W-1:0] prev_key,
   input  logic [lru_kv_pkg::DATA_W-1:0] prev_val,
   output logic                          ent_vld,
   output logic [lru_kv_pkg::DATA_W-1:0] ent_key,
   output logic [lru_kv_pkg::DATA_W-1:0] ent_val
);
   import lru_kv_pkg::*;

   logic              vld_ff,  vld_in;
   logic              mark_ff, mark_in;
   logic [DATA_W-1:0] key_ff,  key_in;
   logic [DATA_W-1:0] val_ff,  val_in;
   pkt_type           pkt_ff,  pkt_in_nxt;
   logic              match;

   assign match = vld_ff && (key_ff == req_key);

   always_comb begin
      pkt_in_nxt = pkt_in;
      mark_in    = mark_ff;
      key_in     = key_ff;
      val_in     = val_ff;
      vld_in     = vld_ff;

      // A live search marks every cell it reaches, ending on a match or on
      // the first empty cell.
      if (pkt_in.act && !pkt_in.done) begin
         mark_in = 1'b1;
         if (match) begin
            pkt_in_nxt.done = 1'b1;
            pkt_in_nxt.hit  = 1'b1;
            pkt_in_nxt.val  = val_ff;
         end else if (!vld_ff) begin
            pkt_in_nxt.done = 1'b1;
         end
      end

      if (upd.commit) begin
         mark_in = 1'b0;
         if (upd.shift && mark_ff) begin
            key_in = prev_key;
            val_in = prev_val;
            vld_in = prev_vld && !(upd.drop_last && !vld_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= 1'b0;
         mark_ff <= 1'b0;
         pkt_ff  <= '0;
      end else begin
         vld_ff  <= vld_in;
         mark_ff <= mark_in;
         pkt_ff  <= pkt_in_nxt;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      val_ff <= val_in;
   end

   assign pkt_out = pkt_ff;
   assign ent_vld = vld_ff;
   assign ent_key = key_ff;
   assign ent_val = val_ff;

   // A cell is only marked by a search word that reached it.
   `ASSERT_CLK(a_mark_from_walk, clock, reset, $rose(mark_ff) |-> $past(pkt_in.act), "cell marked without a search word")

endmodule
